// ===== rtl/core/ptd_pkg.sv =====
// Shared constants, codes and control structs of the periodic task dispatcher.
package ptd_pkg;

  // Table geometry.
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Field widths.
  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 4;
  localparam int PERIOD_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 16;

  // Stream bus widths.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = OPCODE_W;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 1;

  localparam logic [COUNT_W-1:0] WRAP_RESET = 16'd60000;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CREATE  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SUSPEND = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_RESUME  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DELETE  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the accepted input item
    logic apply_edit;   // edit the slot table and send the status item
    logic tick_start;   // advance the tick counter, clear the scan state
    logic div_start;    // start the remainder unit on the current slot
    logic pend_set;     // hold the current slot as the pending fired item
    logic push_pend;    // send the pending fired item, not last
    logic push_final;   // send the closing item of a tick
    logic idx_inc;      // move the scan to the next slot
  } ptd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic eligible;
    logic div_done;
    logic rem_zero;
    logic pend_valid;
    logic idx_last;
    logic out_free;
  } ptd_stat_t;

endpackage

// ===== rtl/core/ptd_div.sv =====
// Iterative remainder unit: one quotient bit per cycle, restoring form.
module ptd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ptd_pkg::COUNT_W-1:0]  dividend,
  input  logic [ptd_pkg::PERIOD_W-1:0] divisor,
  output logic                         done,
  output logic                         rem_zero
);
  import ptd_pkg::*;

  localparam int STEP_W = $clog2(COUNT_W);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [COUNT_W-1:0]  shift;
  logic [PERIOD_W-1:0] dvs;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W:0]   trial;

  assign trial    = {rem, shift[COUNT_W-1]};
  assign rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == STEP_W'(COUNT_W - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == STEP_W'(COUNT_W - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step  <= '0;
      shift <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      step  <= step + STEP_W'(1);
      shift <= {shift[COUNT_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= PERIOD_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[PERIOD_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/ptd_datapath.sv =====
// Datapath: slot table, tick counter, scan index, pending result and output register.
module ptd_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  ptd_pkg::ptd_cmd_t              cmd,
  output ptd_pkg::ptd_stat_t             stat,
  input  logic                           cfg_we,
  input  logic [ptd_pkg::COUNT_W-1:0]    cfg_wdata,
  input  logic [ptd_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [ptd_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ptd_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [ptd_pkg::OUT_USER_W-1:0] m_tuser,
  output logic                           m_tlast
);
  import ptd_pkg::*;

  logic [PERIOD_W-1:0] slot_period [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_present;
  logic [NUM_SLOTS-1:0] slot_resumed;
  logic [COUNT_W-1:0]  tick_counter;
  logic [COUNT_W-1:0]  tick_wrap;
  logic [COUNT_W-1:0]  tick_cnt;

  // Captured input item.
  logic [OPCODE_W-1:0] op;
  logic [INDEX_W-1:0]  op_slot;
  logic [PERIOD_W-1:0] op_period;
  logic                op_handler;

  logic [SLOT_W-1:0]   scan_idx;
  logic [SLOT_W-1:0]   pend_slot;
  logic                pend_valid;

  logic                in_range;
  logic [SLOT_W-1:0]   tbl_idx;
  logic [STATUS_W-1:0] edit_status;
  logic [PERIOD_W-1:0] scan_period;
  logic [COUNT_W-1:0]  cnt_inc;
  logic                out_free;
  logic                div_done;
  logic                rem_zero;

  assign in_range    = ({1'b0, op_slot} < (INDEX_W + 1)'(NUM_SLOTS));
  assign tbl_idx     = op_slot[SLOT_W-1:0];
  assign scan_period = slot_period[scan_idx];
  assign cnt_inc     = tick_counter + COUNT_W'(1);
  assign out_free    = !m_tvalid || m_tready;

  always_comb begin
    edit_status = ST_OK;
    if (op == OP_CREATE || op == OP_SUSPEND || op == OP_RESUME || op == OP_DELETE) begin
      if (!in_range) begin
        edit_status = ST_RANGE;
      end else if (op == OP_CREATE && slot_present[tbl_idx]) begin
        edit_status = ST_OCCUPIED;
      end
    end
  end

  assign stat.is_tick    = (op == OP_TICK);
  assign stat.eligible   = slot_present[scan_idx] && slot_resumed[scan_idx] &&
                           (scan_period != '0);
  assign stat.div_done   = div_done;
  assign stat.rem_zero   = rem_zero;
  assign stat.pend_valid = pend_valid;
  assign stat.idx_last   = (scan_idx == SLOT_W'(NUM_SLOTS - 1));
  assign stat.out_free   = out_free;

  ptd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (tick_cnt),
    .divisor  (scan_period),
    .done     (div_done),
    .rem_zero (rem_zero)
  );

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= s_tuser;
      op_slot    <= s_tdata[INDEX_W-1:0];
      op_period  <= s_tdata[INDEX_W +: PERIOD_W];
      op_handler <= s_tdata[INDEX_W + PERIOD_W];
    end
  end

  // Configuration register and tick counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_wrap    <= WRAP_RESET;
      tick_counter <= '0;
    end else begin
      if (cfg_we) begin
        tick_wrap <= cfg_wdata;
      end
      if (cmd.tick_start) begin
        tick_counter <= (cnt_inc == tick_wrap) ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      tick_cnt <= cnt_inc;
    end
  end

  // Slot table edits.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_present <= '0;
      slot_resumed <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_period[i] <= '0;
      end
    end else if (cmd.apply_edit && in_range) begin
      case (op)
        OP_CREATE: begin
          if (!slot_present[tbl_idx]) begin
            slot_period[tbl_idx]  <= op_period;
            slot_present[tbl_idx] <= op_handler;
            slot_resumed[tbl_idx] <= 1'b1;
          end
        end
        OP_SUSPEND: slot_resumed[tbl_idx] <= 1'b0;
        OP_RESUME:  slot_resumed[tbl_idx] <= 1'b1;
        OP_DELETE:  slot_present[tbl_idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Scan index and pending fired slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.tick_start) begin
      pend_valid <= 1'b0;
    end else if (cmd.pend_set) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      scan_idx <= '0;
    end else if (cmd.idx_inc) begin
      scan_idx <= scan_idx + SLOT_W'(1);
    end
    if (cmd.pend_set) begin
      pend_slot <= scan_idx;
    end
  end

  // Output register. tdata: fired_slot, status, tick_count from bit 0 up.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.apply_edit || cmd.push_pend || cmd.push_final) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply_edit) begin
      m_tuser <= 1'b0;
      m_tlast <= 1'b1;
      m_tdata <= OUT_DATA_W'({COUNT_W'(0), edit_status, INDEX_W'(0)});
    end else if (cmd.push_pend || cmd.push_final) begin
      m_tuser <= pend_valid;
      m_tlast <= cmd.push_final;
      m_tdata <= OUT_DATA_W'({tick_cnt, ST_OK,
                              pend_valid ? INDEX_W'(pend_slot) : INDEX_W'(0)});
    end
  end

endmodule

// ===== rtl/core/ptd_ctrl.sv =====
// Controller state machine: sequences table edits and the slot scan of a tick.
module ptd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output ptd_pkg::ptd_cmd_t  cmd,
  input  ptd_pkg::ptd_stat_t stat
);
  import ptd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EDIT  = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_HIT   = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EDIT;
        end
      end
      S_EDIT: begin
        if (stat.is_tick) begin
          state_next = S_TICK;
        end else if (stat.out_free) begin
          cmd.apply_edit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_TICK: begin
        cmd.tick_start = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        if (stat.eligible) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = stat.rem_zero ? S_HIT : S_NEXT;
        end
      end
      S_HIT: begin
        if (!stat.pend_valid || stat.out_free) begin
          cmd.push_pend = stat.pend_valid;
          cmd.pend_set  = 1'b1;
          state_next    = S_NEXT;
        end
      end
      S_NEXT: begin
        if (stat.idx_last) begin
          state_next = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.push_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/periodic_task_dispatcher.sv =====
// Top level of the periodic task dispatcher: controller, datapath and ports.
//
//   Channel  Direction  Handshake           Contents
//   s_*      in         s_tvalid/s_tready   tuser opcode; tdata slot_index, period,
//                                           handler_present
//   m_*      out        m_tvalid/m_tready   tuser fired; tdata fired_slot, status,
//                                           tick_count; tlast last
//   cfg_*    in         cfg_we              tick_wrap write, no read-back
//
// One item is in work at a time. A create, suspend, resume or delete item
// is taken in S_IDLE; S_EDIT then loads its status item into the output
// register as soon as that register is free, and the block returns to
// S_IDLE for the next item. A tick walks all 16 slots in order; each slot
// that is present, resumed and has a nonzero period runs the bit-serial
// remainder unit, and the next item is taken once the final item is sent.
// A fired slot is held one step so that the final item of a tick can carry
// tlast. A stalled m_tready holds the scan when a result is ready to leave.
// Reset (rst, synchronous) empties the slot table, clears the tick counter
// and loads tick_wrap with 60000.
module periodic_task_dispatcher (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration: tick_wrap.
  input  logic                           cfg_we,
  input  logic [ptd_pkg::COUNT_W-1:0]    cfg_wdata,
  // Input items.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // tdata: slot_index [3:0], period [19:4], handler_present [20], zero fill.
  input  logic [ptd_pkg::IN_DATA_W-1:0]  s_tdata,
  // tuser: opcode [2:0].
  input  logic [ptd_pkg::IN_USER_W-1:0]  s_tuser,
  // Result items.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // tdata: fired_slot [3:0], status [5:4], tick_count [21:6], zero fill.
  output logic [ptd_pkg::OUT_DATA_W-1:0] m_tdata,
  // tuser: fired [0].
  output logic [ptd_pkg::OUT_USER_W-1:0] m_tuser,
  output logic                           m_tlast
);
  import ptd_pkg::*;

  ptd_cmd_t  cmd;
  ptd_stat_t stat;

  // The controller sequences each item; it sees the datapath only through
  // the command and status structs.
  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath holds the slot table, the counter, the remainder unit and
  // the output register that decouples result delivery from the scan.
  ptd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the periodic task dispatcher with a built-in scheduler predictor.
module tb_top;
  import ptd_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int STALL_LIMIT     = 5000;  // cycles with nothing accepted while work is open
  localparam int SETTLE_CYCLES   = 16;    // quiet time after the last result of a phase
  localparam int MAX_REPORTS     = 10;
  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int RES_FIELDS_W    = INDEX_W + STATUS_W + COUNT_W;

  // Opcodes that the block leaves undefined; each one answers with a zero result item with tlast set.
  localparam logic [OPCODE_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic                fired;
    logic [INDEX_W-1:0]  slot;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } dispatch_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [COUNT_W-1:0]    cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [IN_USER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  // Predicted scheduler state, kept in step with every accepted item.
  logic [PERIOD_W-1:0]  task_period [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] task_present;
  logic [NUM_SLOTS-1:0] task_resumed;
  logic [COUNT_W-1:0]   tick_now;
  logic [COUNT_W-1:0]   wrap_value;

  dispatch_result_t dispatch_q[$];  // results still owed by the block, oldest first
  int fault_count = 0;
  int checked_results = 0;

  // Traffic shaping knobs; switched off for whole phases to get stretches without idling.
  bit send_gaps   = 1'b1;
  bit rx_throttle = 1'b1;
  int burst_left  = 0;
  int rx_left     = 0;

  periodic_task_dispatcher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, what);
    end
  endtask

  // Works out the result items that one accepted item causes and updates the predicted state.
  function automatic void dispatch_item(input logic [OPCODE_W-1:0] op,
                                        input logic [INDEX_W-1:0]  idx,
                                        input logic [PERIOD_W-1:0] per,
                                        input logic                hnd);
    dispatch_result_t held;
    dispatch_result_t res;
    bit               have_held;
    int               i;
    held      = '0;
    res       = '0;
    have_held = 1'b0;
    res.last  = 1'b1;
    if (op == OP_TICK) begin
      tick_now = tick_now + 1'b1;
      // A fired slot is only pushed once the next one is found, so the final one can close.
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (task_present[i] && task_resumed[i] && task_period[i] != '0 &&
            (tick_now % task_period[i]) == '0) begin
          if (have_held) dispatch_q.push_back(held);
          held       = '0;
          held.fired = 1'b1;
          held.slot  = i[INDEX_W-1:0];
          held.count = tick_now;
          have_held  = 1'b1;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        dispatch_q.push_back(held);
      end else begin
        res.count = tick_now;
        dispatch_q.push_back(res);
      end
      // The wrap check uses equality only, so a counter already past the wrap keeps climbing.
      if (tick_now == wrap_value) tick_now = '0;
    end else if (op > OP_DELETE) begin
      dispatch_q.push_back(res);
    end else begin
      if (int'(idx) >= NUM_SLOTS) begin
        res.status = ST_RANGE;
      end else begin
        case (op)
          OP_CREATE: begin
            if (task_present[idx]) begin
              res.status = ST_OCCUPIED;
            end else begin
              // Without a handler the slot keeps its period but stays absent.
              task_period[idx]  = per;
              task_present[idx] = hnd;
              task_resumed[idx] = 1'b1;
            end
          end
          OP_SUSPEND: task_resumed[idx] = 1'b0;
          OP_RESUME:  task_resumed[idx] = 1'b1;
          default:    task_present[idx] = 1'b0;
        endcase
      end
      dispatch_q.push_back(res);
    end
  endfunction

  // Presents one item from a falling edge, waits for its acceptance and returns at a
  // falling edge. When the burst goes on, s_tvalid stays high for the next call.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [PERIOD_W-1:0] per, input logic hnd);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_DATA_W - INDEX_W - PERIOD_W - 1){1'b0}}, hnd, per, idx};
    do @(posedge clk); while (!s_tready);
    dispatch_item(op, idx, per, hnd);
    @(negedge clk);
    if (send_gaps) begin
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(0, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stops sending and waits until every owed result has arrived and the block is quiet.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (dispatch_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes tick_wrap; only called while the block is idle.
  task automatic write_wrap(input logic [COUNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    wrap_value = value;
    @(negedge clk);
  endtask

  // Sets the wrap just above the counter and ticks once so the counter restarts from zero.
  task automatic restart_count();
    write_wrap(tick_now + 1'b1);
    send_item(OP_TICK, '0, '0, 1'b0);
    drain_results();
  endtask

  // Create, occupied create, create without handler, period zero, suspend and resume on
  // empty slots, delete, ticks that fire some slots or none, and the undefined opcodes.
  task automatic test_slot_edits();
    send_item(OP_TICK,    4'd0,  16'd0,     1'b0);
    send_item(OP_CREATE,  4'd0,  16'd1,     1'b1);
    send_item(OP_CREATE,  4'd0,  16'd7,     1'b1);
    send_item(OP_CREATE,  4'd3,  16'd2,     1'b0);
    send_item(OP_CREATE,  4'd3,  16'd2,     1'b1);
    send_item(OP_CREATE,  4'd15, 16'hFFFF,  1'b1);
    send_item(OP_CREATE,  4'd7,  16'd0,     1'b1);
    send_item(OP_TICK,    4'd15, 16'hFFFF,  1'b1);
    send_item(OP_SUSPEND, 4'd0,  16'd0,     1'b0);
    send_item(OP_TICK,    4'd0,  16'd0,     1'b0);
    send_item(OP_RESUME,  4'd0,  16'd0,     1'b0);
    send_item(OP_SUSPEND, 4'd9,  16'd0,     1'b0);
    send_item(OP_RESUME,  4'd9,  16'd0,     1'b0);
    send_item(OP_DELETE,  4'd3,  16'd0,     1'b0);
    send_item(OP_TICK,    4'd0,  16'd0,     1'b0);
    send_item(OP_RSVD_5,  4'd15, 16'hFFFF,  1'b1);
    send_item(OP_RSVD_6,  4'd5,  16'h5A5A,  1'b0);
    send_item(OP_RSVD_7,  4'd10, 16'hA5A5,  1'b1);
    send_item(OP_DELETE,  4'd15, 16'd0,     1'b0);
    send_item(OP_DELETE,  4'd7,  16'd0,     1'b0);
    drain_results();
  endtask

  // Fills every slot so that one tick fires all of them, then ticks once more.
  task automatic test_full_table();
    int i;
    for (i = 1; i < NUM_SLOTS; i++) begin
      // The next tick count is 5, so periods 1 and 5 all fire on it.
      send_item(OP_CREATE, i[INDEX_W-1:0], (i % 4 == 1) ? 16'd5 : 16'd1, 1'b1);
    end
    send_item(OP_TICK, '0, '0, 1'b0);
    send_item(OP_TICK, '0, '0, 1'b0);
    drain_results();
  endtask

  // Largest and smallest wrap, a wrap of zero and a wrap lowered below the counter.
  task automatic test_wrap_extremes();
    write_wrap(16'hFFFF);
    send_item(OP_DELETE, 4'd2, '0, 1'b0);
    send_item(OP_TICK, '0, '0, 1'b0);
    send_item(OP_TICK, '0, '0, 1'b0);
    drain_results();
    restart_count();
    write_wrap(16'd1);
    repeat (3) send_item(OP_TICK, '0, '0, 1'b0);
    drain_results();
    write_wrap(16'd0);
    repeat (3) send_item(OP_TICK, '0, '0, 1'b0);
    drain_results();
    write_wrap(16'd2);
    repeat (2) send_item(OP_TICK, '0, '0, 1'b0);
    drain_results();
    restart_count();
  endtask

  task automatic random_item();
    int                  pick;
    int                  sel;
    logic [OPCODE_W-1:0] op;
    logic [PERIOD_W-1:0] per;
    logic                hnd;
    pick = $urandom_range(0, 99);
    per  = PERIOD_W'($urandom_range(0, 65535));
    hnd  = ($urandom_range(0, 9) != 0);
    if (pick < 45) begin
      op = OP_TICK;
    end else if (pick < 67) begin
      op  = OP_CREATE;
      sel = $urandom_range(0, 9);
      // Mostly short periods so that slots fire within a few ticks.
      if (sel == 0) per = '0;
      else if (sel > 2) per = PERIOD_W'($urandom_range(1, 8));
    end else if (pick < 77) begin
      op = OP_SUSPEND;
    end else if (pick < 87) begin
      op = OP_RESUME;
    end else if (pick < 96) begin
      op = OP_DELETE;
    end else begin
      sel = $urandom_range(0, 2);
      op  = (sel == 0) ? OP_RSVD_5 : (sel == 1) ? OP_RSVD_6 : OP_RSVD_7;
    end
    send_item(op, INDEX_W'($urandom_range(0, NUM_SLOTS - 1)), per, hnd);
  endtask

  // Random traffic in phases; each phase sets a wrap a little above the counter so it
  // keeps cycling, and the last phase runs with the largest wrap.
  task automatic test_random_traffic();
    int phase;
    int k;
    int span;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      span = int'(tick_now) + $urandom_range(1, 24);
      if (phase == RANDOM_PHASES - 1 || span > 65535) span = 65535;
      write_wrap(span[COUNT_W-1:0]);
      send_gaps   = (phase != 1);
      rx_throttle = (phase != 2);
      for (k = 0; k < ITEMS_PER_PHASE; k++) random_item();
      drain_results();
    end
    send_gaps   = 1'b1;
    rx_throttle = 1'b1;
  endtask

  // Receiver: alternating runs of ready and stall of random length, or always ready.
  always @(negedge clk) begin
    if (!rx_throttle) begin
      m_tready <= 1'b1;
      rx_left = 0;
    end else if (rx_left > 0) begin
      rx_left--;
    end else if (m_tready) begin
      m_tready <= 1'b0;
      rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
      rx_left = $urandom_range(0, 12);
    end
  end

  // Each accepted result is compared with the oldest owed result.
  always @(posedge clk) begin : check_results
    dispatch_result_t got;
    dispatch_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.fired  = m_tuser[0];
      got.slot   = m_tdata[INDEX_W-1:0];
      got.status = m_tdata[INDEX_W+STATUS_W-1:INDEX_W];
      got.count  = m_tdata[RES_FIELDS_W-1:INDEX_W+STATUS_W];
      got.last   = m_tlast;
      if (dispatch_q.size() == 0) begin
        note_fault($sformatf({"result with nothing owed: fired %0d slot %0d status %0d ",
                              "count %0d last %0d"},
                             got.fired, got.slot, got.status, got.count, got.last));
      end else begin
        want = dispatch_q.pop_front();
        if (got !== want || m_tdata[OUT_DATA_W-1:RES_FIELDS_W] !== '0) begin
          note_fault($sformatf({"result %0d mismatch: expected fired %0d slot %0d status %0d ",
                                "count %0d last %0d, got fired %0d slot %0d status %0d ",
                                "count %0d last %0d fill %0h"},
                               checked_results, want.fired, want.slot, want.status,
                               want.count, want.last, got.fired, got.slot, got.status,
                               got.count, got.last, m_tdata[OUT_DATA_W-1:RES_FIELDS_W]));
        end
      end
      checked_results++;
    end
  end

  // Ends the run when nothing moves on either side while work is still open.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (!s_tvalid && dispatch_q.size() == 0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : run
    int i;
    for (i = 0; i < NUM_SLOTS; i++) task_period[i] = '0;
    task_present = '0;
    task_resumed = '0;
    tick_now     = '0;
    wrap_value   = WRAP_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_slot_edits();
    test_full_table();
    test_wrap_extremes();
    test_random_traffic();
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
